### rtl/lsi_pkg.sv
// ============================================================================
// lsi_pkg: shared types and constants for the line/sphere intersection core
// Item layouts, status codes, arithmetic widths and the sideband records that
// travel along the square-root and divider cell rows.
// ============================================================================
package lsi_pkg;

    // Coordinate format (fixed by the item layout)
    localparam int COORD_W       = 32;
    localparam int RADIUS_W      = COORD_W - 1;
    localparam int FRAC_BITS_DEF = 16;

    // Intermediate widths
    localparam int DIFF_W = COORD_W + 1;          // origin - center
    localparam int A_W    = 2 * COORD_W;          // dir.dir, never negative
    localparam int BS_W   = 2 * COORD_W + 2;      // dir.diff, signed
    localparam int C_W    = 2 * COORD_W + 3;      // diff.diff - r*r, signed
    localparam int BM_W   = 2 * COORD_W + 1;      // |dir.diff|
    localparam int CM_W   = 2 * COORD_W + 2;      // |c|
    localparam int HALF_W = COORD_W + 1;          // split point for wide products
    localparam int PP_W   = 2 * HALF_W;           // partial product width
    localparam int SQ_W   = 4 * COORD_W + 4;      // quarter discriminant, even width
    localparam int DEN_W  = 2 * COORD_W + 1;      // 2a
    localparam int REM_W  = DEN_W + COORD_W;      // divider remainder window

    // Result status codes
    localparam logic [1:0] ST_NO_HIT   = 2'd0;
    localparam logic [1:0] ST_TANGENT  = 2'd1;
    localparam logic [1:0] ST_TWO      = 2'd2;
    localparam logic [1:0] ST_ZERO_DIR = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic        [RADIUS_W-1:0] radius;
    } t_in;

    typedef struct packed {
        logic        [1:0]         status;
        logic signed [COORD_W-1:0] root_plus;
        logic signed [COORD_W-1:0] root_minus;
        logic                      saturated;
    } t_out;

    // Sideband carried along the square-root row
    typedef struct packed {
        logic                   zero_dir;
        logic                   nohit;
        logic                   tangent;
        logic signed [BS_W-1:0] bs;
        logic        [A_W-1:0]  a;
    } t_sq_side;

    // Sideband carried along the divider row
    typedef struct packed {
        logic zero_dir;
        logic nohit;
        logic tangent;
        logic neg_p;
        logic neg_m;
        logic ovf_p;
        logic ovf_m;
    } t_dv_side;

endpackage

### rtl/lsi_front.sv
// ============================================================================
// lsi_front: quadratic coefficient pipeline
// Seven stages: difference, products, dot sums, magnitudes, partial products,
// product assembly, and the quarter discriminant (b/2)^2 - a*c.
// ============================================================================
module lsi_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  lsi_pkg::t_in                i_item,
    output logic                        o_valid,
    output logic [lsi_pkg::SQ_W-1:0]    o_q,
    output lsi_pkg::t_sq_side           o_side
);
    import lsi_pkg::*;

    localparam int NST  = 7;
    localparam int VV_W = 2 * COORD_W;
    localparam int VD_W = 2 * COORD_W + 1;
    localparam int DD_W = 2 * DIFF_W;
    localparam int RR_W = 2 * RADIUS_W;

    logic [NST-1:0] r_vld;

    logic signed [COORD_W-1:0] w_o [3];
    logic signed [COORD_W-1:0] w_v [3];
    logic signed [COORD_W-1:0] w_c [3];

    // stage 1
    logic signed [COORD_W-1:0]  r_v1 [3];
    logic signed [DIFF_W-1:0]   r_d1 [3];
    logic        [RADIUS_W-1:0] r_r1;
    // stage 2
    logic signed [VV_W-1:0] r_vv [3];
    logic signed [VD_W-1:0] r_vd [3];
    logic signed [DD_W-1:0] r_dd [3];
    logic        [RR_W-1:0] r_rr;
    // stage 3
    logic        [A_W-1:0]  r_a3;
    logic signed [BS_W-1:0] r_bs3;
    logic signed [C_W-1:0]  r_c3;
    // stage 4
    logic        [A_W-1:0]  r_a4;
    logic signed [BS_W-1:0] r_bs4;
    logic        [BM_W-1:0] r_bm4;
    logic        [CM_W-1:0] r_cm4;
    logic                   r_cn4;
    logic                   r_zd4;
    // stage 5
    logic        [A_W-1:0]  r_a5;
    logic signed [BS_W-1:0] r_bs5;
    logic                   r_cn5;
    logic                   r_zd5;
    logic        [PP_W-1:0] r_bb_hh, r_bb_hl, r_bb_ll;
    logic        [PP_W-1:0] r_ac_hh, r_ac_hl, r_ac_lh, r_ac_ll;
    // stage 6
    logic        [A_W-1:0]  r_a6;
    logic signed [BS_W-1:0] r_bs6;
    logic                   r_cn6;
    logic                   r_zd6;
    logic        [SQ_W-1:0] r_bsq6;
    logic        [SQ_W-1:0] r_ac6;
    // stage 7
    logic        [SQ_W-1:0] r_q7;
    t_sq_side               r_side7;

    logic [SQ_W:0] n_qs;

    // Unpack the item into per-axis vectors
    always_comb begin
        w_o[0] = i_item.origin_x;
        w_o[1] = i_item.origin_y;
        w_o[2] = i_item.origin_z;
        w_v[0] = i_item.dir_x;
        w_v[1] = i_item.dir_y;
        w_v[2] = i_item.dir_z;
        w_c[0] = i_item.center_x;
        w_c[1] = i_item.center_y;
        w_c[2] = i_item.center_z;
    end

    // Form the discriminant sign test, widened by one bit
    always_comb begin
        if (r_cn6) begin
            n_qs = {1'b0, r_bsq6} + {1'b0, r_ac6};
        end else begin
            n_qs = {1'b0, r_bsq6} - {1'b0, r_ac6};
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // difference and operand capture
            for (int k = 0; k < 3; k++) begin
                r_v1[k] <= w_v[k];
                r_d1[k] <= DIFF_W'(w_o[k]) - DIFF_W'(w_c[k]);
            end
            r_r1 <= i_item.radius;

            // per-axis products
            for (int k = 0; k < 3; k++) begin
                r_vv[k] <= VV_W'(r_v1[k]) * VV_W'(r_v1[k]);
                r_vd[k] <= VD_W'(r_v1[k]) * VD_W'(r_d1[k]);
                r_dd[k] <= DD_W'(r_d1[k]) * DD_W'(r_d1[k]);
            end
            r_rr <= RR_W'(r_r1) * RR_W'(r_r1);

            // dot products
            r_a3  <= $unsigned(r_vv[0]) + $unsigned(r_vv[1]) + $unsigned(r_vv[2]);
            r_bs3 <= BS_W'(r_vd[0]) + BS_W'(r_vd[1]) + BS_W'(r_vd[2]);
            r_c3  <= C_W'(r_dd[0]) + C_W'(r_dd[1]) + C_W'(r_dd[2])
                     - C_W'($signed({1'b0, r_rr}));

            // magnitudes
            r_a4  <= r_a3;
            r_bs4 <= r_bs3;
            r_bm4 <= BM_W'(r_bs3[BS_W-1] ? -r_bs3 : r_bs3);
            r_cm4 <= CM_W'(r_c3[C_W-1] ? -r_c3 : r_c3);
            r_cn4 <= r_c3[C_W-1];
            r_zd4 <= (r_a3 == '0);

            // partial products
            r_a5    <= r_a4;
            r_bs5   <= r_bs4;
            r_cn5   <= r_cn4;
            r_zd5   <= r_zd4;
            r_bb_hh <= PP_W'(r_bm4[BM_W-1:HALF_W]) * PP_W'(r_bm4[BM_W-1:HALF_W]);
            r_bb_hl <= PP_W'(r_bm4[BM_W-1:HALF_W]) * PP_W'(r_bm4[HALF_W-1:0]);
            r_bb_ll <= PP_W'(r_bm4[HALF_W-1:0]) * PP_W'(r_bm4[HALF_W-1:0]);
            r_ac_hh <= PP_W'(r_a4[A_W-1:HALF_W]) * PP_W'(r_cm4[CM_W-1:HALF_W]);
            r_ac_hl <= PP_W'(r_a4[A_W-1:HALF_W]) * PP_W'(r_cm4[HALF_W-1:0]);
            r_ac_lh <= PP_W'(r_a4[HALF_W-1:0]) * PP_W'(r_cm4[CM_W-1:HALF_W]);
            r_ac_ll <= PP_W'(r_a4[HALF_W-1:0]) * PP_W'(r_cm4[HALF_W-1:0]);

            // assemble (b/2)^2 and a*|c|
            r_a6   <= r_a5;
            r_bs6  <= r_bs5;
            r_cn6  <= r_cn5;
            r_zd6  <= r_zd5;
            r_bsq6 <= (SQ_W'(r_bb_hh) << (2 * HALF_W)) + (SQ_W'(r_bb_hl) << (HALF_W + 1))
                      + SQ_W'(r_bb_ll);
            r_ac6  <= (SQ_W'(r_ac_hh) << (2 * HALF_W)) + (SQ_W'(r_ac_hl) << HALF_W)
                      + (SQ_W'(r_ac_lh) << HALF_W) + SQ_W'(r_ac_ll);

            // quarter discriminant and case flags
            r_q7             <= n_qs[SQ_W] ? '0 : n_qs[SQ_W-1:0];
            r_side7.zero_dir <= r_zd6;
            r_side7.nohit    <= n_qs[SQ_W];
            r_side7.tangent  <= (n_qs == '0);
            r_side7.bs       <= r_bs6;
            r_side7.a        <= r_a6;
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_q     = r_q7;
    assign o_side  = r_side7;

endmodule

### rtl/lsi_sqrt_cell.sv
// ============================================================================
// lsi_sqrt_cell: one digit of the floor square root
// Brings down two radicand bits, tries partial root *4 + 1, and hands the
// remainder, root and sideband to the next cell.
// ============================================================================
module lsi_sqrt_cell #(
    parameter int X_W = 164,
    parameter int S_W = 82
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [X_W-1:0]     i_x,
    input  logic [S_W+1:0]     i_rem,
    input  logic [S_W-1:0]     i_root,
    input  lsi_pkg::t_sq_side  i_side,
    output logic               o_valid,
    output logic [X_W-1:0]     o_x,
    output logic [S_W+1:0]     o_rem,
    output logic [S_W-1:0]     o_root,
    output lsi_pkg::t_sq_side  o_side
);
    import lsi_pkg::*;

    logic [S_W+1:0] w_cur;
    logic [S_W+1:0] w_trial;
    logic [S_W+1:0] w_diff;
    logic           w_take;

    logic           r_valid;
    logic [X_W-1:0] r_x;
    logic [S_W+1:0] r_rem;
    logic [S_W-1:0] r_root;
    t_sq_side       r_side;

    // Trial subtract
    assign w_cur   = {i_rem[S_W-1:0], i_x[X_W-1 -: 2]};
    assign w_trial = {i_root, 2'b01};
    assign w_diff  = w_cur - w_trial;
    assign w_take  = (w_cur >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= i_x << 2;
            r_rem  <= w_take ? w_diff : w_cur;
            r_root <= {i_root[S_W-2:0], w_take};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

### rtl/lsi_div_cell.sv
// ============================================================================
// lsi_div_cell: one quotient bit for both roots
// Restoring division step against a fixed divisor window; the remainder
// shifts left after each step so every cell is the same.
// ============================================================================
module lsi_div_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [lsi_pkg::REM_W-1:0]     i_rem_p,
    input  logic [lsi_pkg::REM_W-1:0]     i_rem_m,
    input  logic [lsi_pkg::REM_W-1:0]     i_dsr,
    input  logic [lsi_pkg::COORD_W-1:0]   i_quo_p,
    input  logic [lsi_pkg::COORD_W-1:0]   i_quo_m,
    input  lsi_pkg::t_dv_side             i_side,
    output logic                          o_valid,
    output logic [lsi_pkg::REM_W-1:0]     o_rem_p,
    output logic [lsi_pkg::REM_W-1:0]     o_rem_m,
    output logic [lsi_pkg::REM_W-1:0]     o_dsr,
    output logic [lsi_pkg::COORD_W-1:0]   o_quo_p,
    output logic [lsi_pkg::COORD_W-1:0]   o_quo_m,
    output lsi_pkg::t_dv_side             o_side
);
    import lsi_pkg::*;

    logic               w_take_p, w_take_m;
    logic [REM_W-1:0]   w_sub_p, w_sub_m;

    logic               r_valid;
    logic [REM_W-1:0]   r_rem_p, r_rem_m, r_dsr;
    logic [COORD_W-1:0] r_quo_p, r_quo_m;
    t_dv_side           r_side;

    // Compare and subtract for each lane
    assign w_take_p = (i_rem_p >= i_dsr);
    assign w_take_m = (i_rem_m >= i_dsr);
    assign w_sub_p  = w_take_p ? (i_rem_p - i_dsr) : i_rem_p;
    assign w_sub_m  = w_take_m ? (i_rem_m - i_dsr) : i_rem_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_p <= {w_sub_p[REM_W-2:0], 1'b0};
            r_rem_m <= {w_sub_m[REM_W-2:0], 1'b0};
            r_dsr   <= i_dsr;
            r_quo_p <= {i_quo_p[COORD_W-2:0], w_take_p};
            r_quo_m <= {i_quo_m[COORD_W-2:0], w_take_m};
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem_p = r_rem_p;
    assign o_rem_m = r_rem_m;
    assign o_dsr   = r_dsr;
    assign o_quo_p = r_quo_p;
    assign o_quo_m = r_quo_m;
    assign o_side  = r_side;

endmodule

### rtl/line_sphere_intersect_core.sv
// ============================================================================
// line_sphere_intersect_core: line/sphere intersection roots in fixed point
// Coefficients, discriminant, a row of square-root cells, numerator setup,
// a row of divider cells for both roots, then clipping and an output stage.
// ============================================================================
// Usage:
//   Input channel i_valid / o_stall / i_item carries one query per item:
//   line origin, direction, sphere center and radius in signed fixed point.
//   Output channel o_valid / i_stall / o_result returns one item per query
//   in order: status, the two roots (rounded toward minus infinity, clipped
//   to the coordinate range) and a clip flag.
//   The default coordinate format is Q16.16. One item is taken every
//   cycle while o_stall is low: the square root spends one cell per root
//   bit and the divider one cell per quotient bit, and all cells advance
//   together.
//   When the receiver stalls, the finished item holds in the output
//   register and the next one drops into a skid register; only with the
//   skid register full does o_stall rise and the whole pipe hold.
//   Reset clears all valid bits; no item is in flight afterwards.
// ============================================================================
module line_sphere_intersect_core #(
    parameter int FRAC_BITS = lsi_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  lsi_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_stall,
    output lsi_pkg::t_out o_result
);
    import lsi_pkg::*;

    localparam int X_W   = SQ_W + 2 * FRAC_BITS + 2;
    localparam int S_W   = X_W / 2;
    localparam int N_W   = S_W + 2;
    localparam int M_W   = N_W - 1;
    localparam int CMP_W = (M_W > REM_W) ? M_W : REM_W;

    logic w_en;

    // front end
    logic            w_f_valid;
    logic [SQ_W-1:0] w_f_q;
    t_sq_side        w_f_side;

    // square-root row
    logic           w_sv [0:S_W];
    logic [X_W-1:0] w_sx [0:S_W];
    logic [S_W+1:0] w_sr [0:S_W];
    logic [S_W-1:0] w_sp [0:S_W];
    t_sq_side       w_ss [0:S_W];

    // numerator setup
    logic                    r_p1_valid;
    logic signed [N_W-1:0]   r_p1_num_p, r_p1_num_m;
    logic        [DEN_W-1:0] r_p1_den;
    t_sq_side                r_p1_side;
    logic signed [N_W-1:0]   n_bf, n_s;

    logic                    r_p2_valid;
    logic        [M_W-1:0]   r_p2_mag_p, r_p2_mag_m;
    logic                    r_p2_neg_p, r_p2_neg_m;
    logic        [DEN_W-1:0] r_p2_den;
    t_sq_side                r_p2_side;
    logic signed [N_W-1:0]   n_abs_p, n_abs_m;

    logic                    r_p3_valid;
    logic        [REM_W-1:0] r_p3_rem_p, r_p3_rem_m, r_p3_dsr;
    t_dv_side                r_p3_side;
    logic        [CMP_W-1:0] n_mag_p, n_mag_m, n_lim;
    logic                    n_ovf_p, n_ovf_m;

    // divider row
    logic               w_dv  [0:COORD_W];
    logic [REM_W-1:0]   w_drp [0:COORD_W];
    logic [REM_W-1:0]   w_drm [0:COORD_W];
    logic [REM_W-1:0]   w_dd  [0:COORD_W];
    logic [COORD_W-1:0] w_dqp [0:COORD_W];
    logic [COORD_W-1:0] w_dqm [0:COORD_W];
    t_dv_side           w_ds  [0:COORD_W];

    // finish and output
    logic             r_fin_valid;
    t_out             r_fin;
    t_out             n_fin;
    logic [COORD_W:0] n_lane_p, n_lane_m;
    logic             r_out_valid;
    t_out             r_out;
    logic             r_skid_valid;
    t_out             r_skid;
    logic             w_take;

    // Clip one lane: returns {saturated, code}
    function automatic logic [COORD_W:0] clip_lane(
        input logic [COORD_W-1:0] qm,
        input logic               remnz,
        input logic               neg,
        input logic               ovf
    );
        logic               sat;
        logic [COORD_W-1:0] code;
        logic [COORD_W-1:0] half;
        half = {1'b1, {(COORD_W-1){1'b0}}};
        if (neg) begin
            sat  = ovf || (qm > half) || ((qm == half) && remnz);
            code = sat ? half : (-qm - COORD_W'(remnz));
        end else begin
            sat  = ovf || qm[COORD_W-1];
            code = sat ? ~half : qm;
        end
        return {sat, code};
    endfunction

    // Hold the whole pipe only while the skid register is occupied
    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign w_take  = r_out_valid && !i_stall;

    lsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (w_f_valid),
        .o_q     (w_f_q),
        .o_side  (w_f_side)
    );

    // Square-root row
    assign w_sv[0] = w_f_valid;
    assign w_sx[0] = {w_f_q, {(2 * FRAC_BITS + 2){1'b0}}};
    assign w_sr[0] = '0;
    assign w_sp[0] = '0;
    assign w_ss[0] = w_f_side;

    for (genvar g = 0; g < S_W; g++) begin : g_sqrt
        lsi_sqrt_cell #(
            .X_W (X_W),
            .S_W (S_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sv[g]),
            .i_x     (w_sx[g]),
            .i_rem   (w_sr[g]),
            .i_root  (w_sp[g]),
            .i_side  (w_ss[g]),
            .o_valid (w_sv[g+1]),
            .o_x     (w_sx[g+1]),
            .o_rem   (w_sr[g+1]),
            .o_root  (w_sp[g+1]),
            .o_side  (w_ss[g+1])
        );
    end

    // Numerators: +-S - b*2^F, with b = 2*bs
    assign n_bf = N_W'(w_ss[S_W].bs) <<< (FRAC_BITS + 1);
    assign n_s  = $signed({2'b00, w_sp[S_W]});

    // Magnitudes
    assign n_abs_p = r_p1_num_p[N_W-1] ? -r_p1_num_p : r_p1_num_p;
    assign n_abs_m = r_p1_num_m[N_W-1] ? -r_p1_num_m : r_p1_num_m;

    // Overflow: quotient magnitude would reach 2^COORD_W
    assign n_mag_p = CMP_W'(r_p2_mag_p);
    assign n_mag_m = CMP_W'(r_p2_mag_m);
    assign n_lim   = CMP_W'(r_p2_den) << COORD_W;
    assign n_ovf_p = (n_mag_p >= n_lim);
    assign n_ovf_m = (n_mag_m >= n_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid <= w_sv[S_W];
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_num_p <= n_s - n_bf;
            r_p1_num_m <= -n_s - n_bf;
            r_p1_den   <= {w_ss[S_W].a, 1'b0};
            r_p1_side  <= w_ss[S_W];

            r_p2_mag_p <= n_abs_p[M_W-1:0];
            r_p2_mag_m <= n_abs_m[M_W-1:0];
            r_p2_neg_p <= r_p1_num_p[N_W-1];
            r_p2_neg_m <= r_p1_num_m[N_W-1];
            r_p2_den   <= r_p1_den;
            r_p2_side  <= r_p1_side;

            r_p3_rem_p         <= n_ovf_p ? '0 : n_mag_p[REM_W-1:0];
            r_p3_rem_m         <= n_ovf_m ? '0 : n_mag_m[REM_W-1:0];
            r_p3_dsr           <= REM_W'(r_p2_den) << (COORD_W - 1);
            r_p3_side.zero_dir <= r_p2_side.zero_dir;
            r_p3_side.nohit    <= r_p2_side.nohit;
            r_p3_side.tangent  <= r_p2_side.tangent;
            r_p3_side.neg_p    <= r_p2_neg_p;
            r_p3_side.neg_m    <= r_p2_neg_m;
            r_p3_side.ovf_p    <= n_ovf_p;
            r_p3_side.ovf_m    <= n_ovf_m;
        end
    end

    // Divider row
    assign w_dv[0]  = r_p3_valid;
    assign w_drp[0] = r_p3_rem_p;
    assign w_drm[0] = r_p3_rem_m;
    assign w_dd[0]  = r_p3_dsr;
    assign w_dqp[0] = '0;
    assign w_dqm[0] = '0;
    assign w_ds[0]  = r_p3_side;

    for (genvar g = 0; g < COORD_W; g++) begin : g_div
        lsi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[g]),
            .i_rem_p (w_drp[g]),
            .i_rem_m (w_drm[g]),
            .i_dsr   (w_dd[g]),
            .i_quo_p (w_dqp[g]),
            .i_quo_m (w_dqm[g]),
            .i_side  (w_ds[g]),
            .o_valid (w_dv[g+1]),
            .o_rem_p (w_drp[g+1]),
            .o_rem_m (w_drm[g+1]),
            .o_dsr   (w_dd[g+1]),
            .o_quo_p (w_dqp[g+1]),
            .o_quo_m (w_dqm[g+1]),
            .o_side  (w_ds[g+1])
        );
    end

    // Clip roots and pick the status
    assign n_lane_p = clip_lane(w_dqp[COORD_W], (w_drp[COORD_W] != '0),
                                w_ds[COORD_W].neg_p, w_ds[COORD_W].ovf_p);
    assign n_lane_m = clip_lane(w_dqm[COORD_W], (w_drm[COORD_W] != '0),
                                w_ds[COORD_W].neg_m, w_ds[COORD_W].ovf_m);

    always_comb begin
        n_fin = '0;
        priority if (w_ds[COORD_W].zero_dir) begin
            n_fin.status = ST_ZERO_DIR;
        end else if (w_ds[COORD_W].nohit) begin
            n_fin.status = ST_NO_HIT;
        end else if (w_ds[COORD_W].tangent) begin
            n_fin.status    = ST_TANGENT;
            n_fin.root_plus = n_lane_p[COORD_W-1:0];
            n_fin.saturated = n_lane_p[COORD_W];
        end else begin
            n_fin.status     = ST_TWO;
            n_fin.root_plus  = n_lane_p[COORD_W-1:0];
            n_fin.root_minus = n_lane_m[COORD_W-1:0];
            n_fin.saturated  = n_lane_p[COORD_W] | n_lane_m[COORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_en) begin
            r_fin_valid <= w_dv[COORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= n_fin;
        end
    end

    // Output register with skid: drain skid first, else take the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r_fin_valid;
            end
        end else if (w_en && r_fin_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            r_out <= r_skid_valid ? r_skid : r_fin;
        end else if (w_en && r_fin_valid) begin
            r_skid <= r_fin;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // The skid register is only occupied behind a waiting output item
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item with output register empty");

    // The skid register only fills when the output item was held
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid register filled without a held output item");

    // Zero direction reports no roots and no clipping
    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_ZERO_DIR) |->
        (r_out.root_plus == '0 && r_out.root_minus == '0 && !r_out.saturated))
        else $error("zero direction item carries roots");

    // The minus root never lies above the plus root
    a_root_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_TWO) |->
        (r_out.root_minus <= r_out.root_plus))
        else $error("root order violated");

endmodule

### verif/line_sphere_intersect_core_tb.sv
// ============================================================================
// line_sphere_intersect_core_tb: self-checking bench for the intersection core
// Feeds directed and random line/sphere queries through a valid/stall driver,
// predicts status and both roots with exact wide arithmetic, and compares
// every result item in order. The receiver stalls at random and once holds
// off long enough for the pipe to fill and stall its input.
// ============================================================================
module line_sphere_intersect_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lsi_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LATENCY = 127;
    localparam int N_RANDOM = 1430;

    typedef logic signed [299:0] t_wide;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_in   i_item = '0;
    logic  o_valid;
    logic  i_stall = 1'b0;
    t_out  o_result;

    t_in   pending_q[$];
    t_out  expected_q[$];
    bit    stim_done = 1'b0;
    bit    hold_long = 1'b0;
    bit    in_acc = 1'b0;
    int    n_fail = 0;
    int    gap_cnt = 0;

    line_sphere_intersect_core uut (.*);

    always #5 i_clk = ~i_clk;

    // floor square root of a nonnegative wide value
    function automatic t_wide isqrt_floor(input t_wide v);
        t_wide res, bitv, num;
        res = 0;
        num = v;
        bitv = t_wide'(1) << 296;
        while (bitv > num) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (num >= res + bitv) begin
                num = num - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // floor division by a positive denominator
    function automatic t_wide floor_div(input t_wide n, input t_wide d);
        t_wide qt;
        qt = n / d;
        if (n < 0 && qt * d != n) qt = qt - 1;
        return qt;
    endfunction

    function automatic logic [COORD_W-1:0] clip_coord(input t_wide v, inout logic sat);
        t_wide hi, lo;
        hi = t_wide'(64'sh7fffffff);
        lo = -t_wide'(64'sh80000000);
        if (v > hi) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < lo) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[COORD_W-1:0];
    endfunction

    // compute the expected intersection result of one query
    function automatic t_out intersect_roots(input t_in it);
        t_wide a, b, c, o, v, p, dd, q, s, bf, den, rr;
        t_out  r;
        logic  sat;
        logic signed [COORD_W-1:0] os[3], vs[3], ps[3];
        os = '{it.origin_x, it.origin_y, it.origin_z};
        vs = '{it.dir_x, it.dir_y, it.dir_z};
        ps = '{it.center_x, it.center_y, it.center_z};
        r = '0;
        sat = 1'b0;
        a = 0; b = 0; c = 0;
        for (int k = 0; k < 3; k++) begin
            o = os[k]; v = vs[k]; p = ps[k];
            dd = o - p;
            a = a + v * v;
            b = b + v * dd;
            c = c + dd * dd;
        end
        b = b * 2;
        rr = t_wide'({1'b0, it.radius});
        c = c - rr * rr;
        if (a == 0) begin
            r.status = ST_ZERO_DIR;
            return r;
        end
        q = b * b - 4 * a * c;
        if (q < 0) begin
            r.status = ST_NO_HIT;
            return r;
        end
        s = isqrt_floor(q << (2 * FRAC));
        bf = b << FRAC;
        den = a * 2;
        r.root_plus = clip_coord(floor_div(s - bf, den), sat);
        if (q == 0) begin
            r.status = ST_TANGENT;
        end else begin
            r.root_minus = clip_coord(floor_div(-s - bf, den), sat);
            r.status = ST_TWO;
        end
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return 32'($signed($urandom_range(0, 512)) - 256);
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
        endcase
    endfunction

    // build a random query, mostly with the line passing near the sphere
    function automatic t_in random_query();
        t_in it;
        int  m;
        m = $urandom_range(0, 9);
        it.origin_x = rand_coord(m < 6 ? 1 : $urandom_range(0, 4));
        it.origin_y = rand_coord(m < 6 ? 1 : $urandom_range(0, 4));
        it.origin_z = rand_coord(m < 6 ? 1 : $urandom_range(0, 4));
        it.dir_x = rand_coord(m < 6 ? 1 : $urandom_range(0, 4));
        it.dir_y = rand_coord(m < 6 ? 1 : $urandom_range(0, 4));
        it.dir_z = rand_coord(m < 6 ? 1 : $urandom_range(0, 4));
        it.center_x = rand_coord(m < 6 ? 1 : $urandom_range(0, 4));
        it.center_y = rand_coord(m < 6 ? 1 : $urandom_range(0, 4));
        it.center_z = rand_coord(m < 6 ? 1 : $urandom_range(0, 4));
        it.radius = m < 6 ? 31'($urandom_range(0, 4 << 16)) : 31'($urandom());
        if (m == 9) begin
            it.dir_x = '0; it.dir_y = '0; it.dir_z = '0;
        end else if (m == 8) begin
            it.dir_x = 32'($signed($urandom_range(0, 6)) - 3);
        end
        return it;
    endfunction

    // fill the stimulus queue: directed cases, then random queries
    initial begin
        t_in it;
        it = '0;
        it.dir_x = 32'h0001_0000; it.radius = 31'h0001_0000;
        pending_q.push_back(it);                          // two roots at -1, +1
        it.origin_y = 32'h0001_0000;
        pending_q.push_back(it);                          // tangent
        it.origin_y = 32'h0002_0000;
        pending_q.push_back(it);                          // no hit
        it.dir_x = '0;
        pending_q.push_back(it);                          // zero direction
        it = '0; it.dir_x = 32'sd1; it.radius = 31'h7fffffff;
        pending_q.push_back(it);                          // roots clip both ways
        it = '0; it.dir_x = 32'h7fffffff; it.dir_y = 32'h80000000;
        it.dir_z = 32'h7fffffff; it.radius = 31'h7fffffff;
        it.origin_x = 32'h80000000; it.center_x = 32'h7fffffff;
        it.origin_y = 32'h7fffffff; it.center_y = 32'h80000000;
        pending_q.push_back(it);
        it = '1;
        pending_q.push_back(it);
        it = '0; it.dir_z = 32'h80000000; it.center_z = 32'h7fffffff;
        pending_q.push_back(it);
        it = '0; it.dir_y = 32'sd3; it.origin_y = 32'h0005_0000;
        it.radius = 31'h0002_0000;
        pending_q.push_back(it);                          // non-unit direction
        it = '0; it.dir_x = 32'hffff_0000; it.dir_y = 32'h0000_8000;
        it.origin_x = 32'h0003_0000; it.radius = 31'h0001_8000;
        pending_q.push_back(it);
        for (int i = 0; i < N_RANDOM; i++) pending_q.push_back(random_query());
    end

    // driver: offer items with random gaps, change inputs on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_acc) begin
            // hold the item until it is taken
        end else if (gap_cnt > 0) begin
            gap_cnt <= gap_cnt - 1;
            i_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
            i_item <= pending_q.pop_front();
            i_valid <= 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2: gap_cnt <= $urandom_range(1, 3);
                3: gap_cnt <= $urandom_range(10, 40);
                default: gap_cnt <= 0;
            endcase
        end else begin
            i_valid <= 1'b0;
            stim_done <= 1'b1;
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_long) begin
            i_stall <= 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2: i_stall <= 1'b1;
                3: i_stall <= ($urandom_range(0, 1) == 1);
                default: i_stall <= 1'b0;
            endcase
        end
    end

    initial begin
        int cnt;
        cnt = 0;
        wait (i_rst_n);
        repeat (400) @(posedge i_clk);
        hold_long = 1'b1;
        while (cnt < 300) begin
            @(posedge i_clk);
            cnt++;
        end
        hold_long = 1'b0;
    end

    // note acceptance and predict on every accepted query
    always @(posedge i_clk) begin
        in_acc <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) expected_q.push_back(intersect_roots(i_item));
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result item %p", o_result);
                n_fail++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_result.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_result.status);
                    n_fail++;
                end
                if (o_result.root_plus !== exp_r.root_plus) begin
                    $error("root_plus: expected %h, got %h",
                           exp_r.root_plus, o_result.root_plus);
                    n_fail++;
                end
                if (o_result.root_minus !== exp_r.root_minus) begin
                    $error("root_minus: expected %h, got %h",
                           exp_r.root_minus, o_result.root_minus);
                    n_fail++;
                end
                if (o_result.saturated !== exp_r.saturated) begin
                    $error("saturated: expected %0d, got %0d",
                           exp_r.saturated, o_result.saturated);
                    n_fail++;
                end
            end
        end
    end

    // reset, then wait for the pipe to drain
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        wait (expected_q.size() == 0);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("line_sphere_intersect_core_tb passed");
        end else begin
            $display("line_sphere_intersect_core_tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("line_sphere_intersect_core_tb failed");
        $finish;
    end

endmodule
